[rtl/tam_pkg.sv]
`timescale 1ns / 1ps
package tam_pkg;
    localparam int unsigned CFG_W = 7;
    localparam int unsigned PIX_W = 8;
    localparam int unsigned POS_W = 6;
    localparam int unsigned SUM_W = 20;

    localparam int unsigned MAX_WIDTH  = 64;
    localparam int unsigned MAX_HEIGHT = 64;
    localparam int unsigned TC_W  = $clog2(MAX_WIDTH);
    localparam int unsigned TR_W  = $clog2(MAX_HEIGHT);
    localparam int unsigned ADR_W = TC_W + TR_W;
    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;

    localparam logic [1:0] REG_IMG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TILE_SIZE  = 2'd2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
        logic [POS_W-1:0] read_col;
        logic [POS_W-1:0] read_row;
    } tam_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_avg;
        logic [PIX_W-1:0] green_avg;
        logic [PIX_W-1:0] blue_avg;
    } tam_out_t;

    typedef struct packed {
        logic capture;
        logic locate;
        logic mem_rd;
        logic mem_wr;
        logic div_start;
        logic div_step;
        logic out_load;
    } tam_cmd_t;

    typedef struct packed {
        logic is_read;
        logic loc_done;
        logic div_done;
    } tam_sts_t;
endpackage

[rtl/tam_ctrl.sv]
`timescale 1ns / 1ps
module tam_ctrl
    import tam_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output tam_cmd_t cmd,
    input  tam_sts_t sts
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_LOCATE, ST_FETCH, ST_ACCUM, ST_SETUP, ST_DIV
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd = '0;
        cmd.capture = s_valid && s_ready;
        cmd.locate = (state_reg == ST_LOCATE) && !sts.loc_done;
        cmd.mem_rd = (state_reg == ST_FETCH);
        cmd.mem_wr = (state_reg == ST_ACCUM);
        cmd.div_start = (state_reg == ST_SETUP);
        cmd.div_step = (state_reg == ST_DIV) && !sts.div_done;
        cmd.out_load = (state_reg == ST_DIV) && sts.div_done && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:   if (s_valid) state_reg <= ST_LOCATE;
                ST_LOCATE: if (sts.loc_done) state_reg <= ST_FETCH;
                ST_FETCH:  state_reg <= sts.is_read ? ST_SETUP : ST_ACCUM;
                ST_ACCUM:  state_reg <= ST_IDLE;
                ST_SETUP:  state_reg <= ST_DIV;
                ST_DIV: begin
                    if (cmd.out_load) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

[rtl/tam_datapath.sv]
`timescale 1ns / 1ps
module tam_datapath
    import tam_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  tam_in_t          s_data,
    input  tam_cmd_t         cmd,
    output tam_sts_t         sts,
    output tam_out_t         m_data
);
    localparam int unsigned CNT_W  = 2 * CFG_W;
    localparam int unsigned STEP_W = $clog2(SUM_W + 1);
    localparam logic [CFG_W-1:0] MAXW_C = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] MAXH_C = CFG_W'(MAX_HEIGHT);

    logic [CFG_W-1:0]   img_w_reg, img_h_reg, tile_reg;
    logic [POS_W-1:0]   load_col_reg, load_row_reg;
    tam_in_t            item_reg;
    logic [3*SUM_W-1:0] mem [DEPTH];
    logic [3*SUM_W-1:0] rd_reg;
    logic [ADR_W-1:0]   adr_reg;
    logic [ADR_W-1:0]   rd_adr;
    logic               first_reg;
    logic [CFG_W-1:0]   w_eff, h_eff, ts_eff;
    logic [CFG_W-1:0]   cap_col, cap_row;
    // tile index and offset found by running subtraction: tile counts are small
    logic [CFG_W-1:0]   tc_reg, tr_reg, x0_reg, y0_reg, xr_reg, yr_reg;
    logic [CFG_W-1:0]   tw, th;
    logic [CNT_W-1:0]   cnt_reg;
    logic [3*SUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]   rem_reg [3];
    logic [CNT_W-1:0]   rem_next [3];
    logic [CNT_W:0]     part_c [3];
    logic [CNT_W:0]     diff_c [3];
    logic [2:0]         take_c;
    logic [STEP_W-1:0]  step_reg;
    tam_out_t           out_reg;

    assign w_eff  = (img_w_reg == '0) ? CFG_W'(1) : ((img_w_reg > MAXW_C) ? MAXW_C : img_w_reg);
    assign h_eff  = (img_h_reg == '0) ? CFG_W'(1) : ((img_h_reg > MAXH_C) ? MAXH_C : img_h_reg);
    assign ts_eff = (tile_reg == '0) ? CFG_W'(1) : tile_reg;

    always_comb begin
        cap_col = {1'b0, (s_data.opcode == OP_READ) ? s_data.read_col : load_col_reg};
        cap_row = {1'b0, (s_data.opcode == OP_READ) ? s_data.read_row : load_row_reg};
        if (s_data.opcode == OP_READ && cap_col >= w_eff) cap_col = w_eff - CFG_W'(1);
        if (s_data.opcode == OP_READ && cap_row >= h_eff) cap_row = h_eff - CFG_W'(1);
    end

    assign tw = (w_eff - x0_reg < ts_eff) ? w_eff - x0_reg : ts_eff;
    assign th = (h_eff - y0_reg < ts_eff) ? h_eff - y0_reg : ts_eff;
    assign rd_adr = {tr_reg[TR_W-1:0], tc_reg[TC_W-1:0]};

    assign sts.is_read  = item_reg.opcode == OP_READ;
    assign sts.loc_done = (xr_reg < ts_eff) && (yr_reg < ts_eff);
    assign sts.div_done = (step_reg == '0);
    assign m_data = out_reg;

    function automatic logic [PIX_W-1:0] sat8(input logic [SUM_W-1:0] q);
        return (q > SUM_W'(255)) ? PIX_W'(255) : q[PIX_W-1:0];
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            part_c[i] = {rem_reg[i], quo_reg[i*SUM_W + SUM_W - 1]};
            take_c[i] = part_c[i] >= {1'b0, cnt_reg};
            diff_c[i] = part_c[i] - {1'b0, cnt_reg};
            rem_next[i] = take_c[i] ? diff_c[i][CNT_W-1:0] : part_c[i][CNT_W-1:0];
            quo_next[i*SUM_W +: SUM_W] = {quo_reg[i*SUM_W +: SUM_W-1], take_c[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_w_reg    <= CFG_W'(64);
            img_h_reg    <= CFG_W'(64);
            tile_reg     <= CFG_W'(8);
            load_col_reg <= '0;
            load_row_reg <= '0;
            step_reg     <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_IMG_WIDTH:  img_w_reg <= cfg_data;
                    REG_IMG_HEIGHT: img_h_reg <= cfg_data;
                    REG_TILE_SIZE:  tile_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.mem_wr) begin
                if ({1'b0, load_col_reg} + CFG_W'(1) >= w_eff) begin
                    load_col_reg <= '0;
                    load_row_reg <= ({1'b0, load_row_reg} + CFG_W'(1) >= h_eff) ? '0
                                    : load_row_reg + POS_W'(1);
                end else begin
                    load_col_reg <= load_col_reg + POS_W'(1);
                end
            end
            if (cmd.div_start) begin
                step_reg <= STEP_W'(SUM_W);
            end else if (cmd.div_step) begin
                step_reg <= step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
            xr_reg   <= cap_col;
            yr_reg   <= cap_row;
            tc_reg   <= '0;
            tr_reg   <= '0;
            x0_reg   <= '0;
            y0_reg   <= '0;
        end else if (cmd.locate) begin
            if (xr_reg >= ts_eff) begin
                xr_reg <= xr_reg - ts_eff;
                tc_reg <= tc_reg + CFG_W'(1);
                x0_reg <= x0_reg + ts_eff;
            end
            if (yr_reg >= ts_eff) begin
                yr_reg <= yr_reg - ts_eff;
                tr_reg <= tr_reg + CFG_W'(1);
                y0_reg <= y0_reg + ts_eff;
            end
        end
        if (cmd.mem_rd) begin
            adr_reg   <= rd_adr;
            first_reg <= (xr_reg == '0) && (yr_reg == '0);
            cnt_reg   <= CNT_W'(tw) * CNT_W'(th);
        end
        if (cmd.div_start) begin
            quo_reg <= rd_reg;
            for (int i = 0; i < 3; i++) rem_reg[i] <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= quo_next;
            for (int i = 0; i < 3; i++) rem_reg[i] <= rem_next[i];
        end
        if (cmd.out_load) begin
            out_reg.red_avg   <= sat8(quo_reg[3*SUM_W-1:2*SUM_W]);
            out_reg.green_avg <= sat8(quo_reg[2*SUM_W-1:SUM_W]);
            out_reg.blue_avg  <= sat8(quo_reg[SUM_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_rd) begin
            rd_reg <= mem[rd_adr];
        end
        if (cmd.mem_wr) begin
            if (first_reg) begin
                mem[adr_reg] <= {SUM_W'(item_reg.red_in), SUM_W'(item_reg.green_in),
                                 SUM_W'(item_reg.blue_in)};
            end else begin
                mem[adr_reg] <= {rd_reg[3*SUM_W-1:2*SUM_W] + SUM_W'(item_reg.red_in),
                                 rd_reg[2*SUM_W-1:SUM_W] + SUM_W'(item_reg.green_in),
                                 rd_reg[SUM_W-1:0] + SUM_W'(item_reg.blue_in)};
            end
        end
    end
endmodule

[rtl/tile_average_mosaic_top.sv]
`timescale 1ns / 1ps
// Load: tile locate, fetch, then add into the tile sum; read: tile locate, fetch,
// divider setup, divide, then the result register. Column / tile and row / tile
// (0 to 63) come from the subtraction loop; reads add a 20-step restoring divider
// per color. One item in flight at a time; the result register frees the input
// while a result waits, and a following read holds in the divider until it drains.
// Reset (aresetn low, synchronous) clears the load position and control;
// registers go to 64, 64, 8. Tile sums are not cleared.
module tile_average_mosaic_top
    import tam_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  tam_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output tam_out_t         m_data
);
    tam_cmd_t cmd;
    tam_sts_t sts;

    assign cfg_ready = 1'b1;

    tam_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .cmd, .sts
    );

    tam_datapath u_dp (
        .aclk, .aresetn, .cfg_valid, .cfg_index, .cfg_data, .s_data, .cmd, .sts, .m_data
    );

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result lost");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.locate, cmd.mem_rd, cmd.mem_wr, cmd.div_start, cmd.div_step,
                  cmd.out_load}))
        else $error("command overlap");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !s_ready) else $error("accept during divide");
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
    import tam_pkg::*;

    localparam int unsigned GRID = 64;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned DRAIN_CYCLES = 200;

    class tile_avg_model;
        bit [SUM_W-1:0] red_sum[GRID*GRID];
        bit [SUM_W-1:0] green_sum[GRID*GRID];
        bit [SUM_W-1:0] blue_sum[GRID*GRID];
        bit             sum_valid[GRID*GRID];
        int unsigned    next_col;
        int unsigned    next_row;
        bit [CFG_W-1:0] width_reg;
        bit [CFG_W-1:0] height_reg;
        bit [CFG_W-1:0] tile_reg;
        tam_out_t       pending_avgs[$];
        int unsigned    errors;

        function new();
            next_col = 0;
            next_row = 0;
            width_reg = 64;
            height_reg = 64;
            tile_reg = 8;
            errors = 0;
        endfunction

        function int unsigned eff_width();
            return width_reg == 0 ? 1 : (width_reg > GRID ? GRID : width_reg);
        endfunction

        function int unsigned eff_height();
            return height_reg == 0 ? 1 : (height_reg > GRID ? GRID : height_reg);
        endfunction

        function int unsigned eff_tile();
            return tile_reg == 0 ? 1 : tile_reg;
        endfunction

        function int unsigned tile_index(int unsigned col, int unsigned row);
            int unsigned tc;
            int unsigned tr;
            tc = col / eff_tile();
            tr = row / eff_tile();
            if (tc >= GRID) tc = GRID - 1;
            if (tr >= GRID) tr = GRID - 1;
            return tr * GRID + tc;
        endfunction

        function int unsigned sat_col(int unsigned col);
            return col >= eff_width() ? eff_width() - 1 : col;
        endfunction

        function int unsigned sat_row(int unsigned row);
            return row >= eff_height() ? eff_height() - 1 : row;
        endfunction

        function bit readable(int unsigned col, int unsigned row);
            return sum_valid[tile_index(sat_col(col), sat_row(row))];
        endfunction

        function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_IMG_WIDTH:  width_reg = val;
                REG_IMG_HEIGHT: height_reg = val;
                REG_TILE_SIZE:  tile_reg = val;
                default: ;
            endcase
        endfunction

        function bit [PIX_W-1:0] avg8(bit [SUM_W-1:0] s, int unsigned cnt);
            int unsigned a;
            a = s / cnt;
            return a > 255 ? 8'd255 : a[PIX_W-1:0];
        endfunction

        function void note_item(tam_in_t d);
            int unsigned a;
            int unsigned ts;
            int unsigned col;
            int unsigned row;
            int unsigned x0;
            int unsigned y0;
            int unsigned tw;
            int unsigned th;
            tam_out_t    res;
            ts = eff_tile();
            if (d.opcode == OP_LOAD) begin
                a = tile_index(next_col, next_row);
                if ((next_col % ts == 0) && (next_row % ts == 0)) begin
                    red_sum[a] = d.red_in;
                    green_sum[a] = d.green_in;
                    blue_sum[a] = d.blue_in;
                    sum_valid[a] = 1'b1;
                end else begin
                    red_sum[a] = red_sum[a] + d.red_in;
                    green_sum[a] = green_sum[a] + d.green_in;
                    blue_sum[a] = blue_sum[a] + d.blue_in;
                end
                next_col++;
                if (next_col >= eff_width()) begin
                    next_col = 0;
                    next_row++;
                    if (next_row >= eff_height()) next_row = 0;
                end
            end else begin
                col = sat_col(d.read_col);
                row = sat_row(d.read_row);
                x0 = (col / ts) * ts;
                y0 = (row / ts) * ts;
                tw = (eff_width() - x0 < ts) ? eff_width() - x0 : ts;
                th = (eff_height() - y0 < ts) ? eff_height() - y0 : ts;
                a = tile_index(col, row);
                res.red_avg = avg8(red_sum[a], tw * th);
                res.green_avg = avg8(green_sum[a], tw * th);
                res.blue_avg = avg8(blue_sum[a], tw * th);
                pending_avgs.push_back(res);
            end
        endfunction

        function void check_avg(tam_out_t got);
            tam_out_t want;
            if (pending_avgs.size() == 0) begin
                $error("unexpected result transfer %h", got);
                errors++;
                return;
            end
            want = pending_avgs.pop_front();
            if (got.red_avg !== want.red_avg) begin
                $error("red_avg expected %0d actual %0d", want.red_avg, got.red_avg);
                errors++;
            end
            if (got.green_avg !== want.green_avg) begin
                $error("green_avg expected %0d actual %0d", want.green_avg, got.green_avg);
                errors++;
            end
            if (got.blue_avg !== want.blue_avg) begin
                $error("blue_avg expected %0d actual %0d", want.blue_avg, got.blue_avg);
                errors++;
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             s_valid;
    logic             s_ready;
    tam_in_t          s_data;
    logic             m_valid;
    logic             m_ready;
    tam_out_t         m_data;

    tile_avg_model model;
    bit            quiet;
    bit            hold_req;
    int unsigned   cycles;
    int unsigned   items_sent;

    tile_average_mosaic_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tile_average_mosaic_top test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) model.check_avg(m_data);
    end

    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= 21);
                @(posedge aclk);
            end
        end
    end

    task automatic send_item(tam_in_t d);
        if (!quiet && $urandom_range(99) < 21) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= d;
        do @(posedge aclk); while (!s_ready);
        model.note_item(d);
        items_sent++;
    endtask

    task automatic load_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        tam_in_t d;
        d = '0;
        d.opcode = OP_LOAD;
        d.red_in = r;
        d.green_in = g;
        d.blue_in = b;
        d.read_col = $urandom;
        d.read_row = $urandom;
        send_item(d);
    endtask

    task automatic read_pixel(logic [5:0] col, logic [5:0] row);
        tam_in_t d;
        d = '0;
        d.opcode = OP_READ;
        d.red_in = $urandom;
        d.green_in = $urandom;
        d.blue_in = $urandom;
        d.read_col = col;
        d.read_row = row;
        send_item(d);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (model.pending_avgs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        model.write_reg(idx, val);
    endtask

    task automatic configure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [CFG_W-1:0] t);
        drain();
        write_reg(REG_IMG_WIDTH, w);
        write_reg(REG_IMG_HEIGHT, h);
        write_reg(REG_TILE_SIZE, t);
    endtask

    function automatic logic [7:0] rand_pix();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_item(int unsigned read_pct);
        logic [5:0] col;
        logic [5:0] row;
        if ($urandom_range(99) < read_pct) begin
            if ($urandom_range(9) == 0) begin
                col = $urandom;
                row = $urandom;
            end else begin
                col = $urandom_range(model.eff_width() - 1);
                row = $urandom_range(model.eff_height() - 1);
            end
            if (model.readable(col, row)) begin
                read_pixel(col, row);
                return;
            end
        end
        load_pixel(rand_pix(), rand_pix(), rand_pix());
    endtask

    initial begin
        int unsigned n;
        int unsigned sel;
        model = new();
        quiet = 1'b0;
        hold_req = 1'b0;
        cycles = 0;
        items_sent = 0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_IMG_WIDTH;
        cfg_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        configure(5, 3, 2);
        load_pixel(8'd255, 8'd255, 8'd255);
        load_pixel(8'd0, 8'd0, 8'd0);
        load_pixel(8'd255, 8'd0, 8'd128);
        load_pixel(8'd1, 8'd254, 8'd127);
        load_pixel(8'd255, 8'd255, 8'd255);
        repeat (10) load_pixel(rand_pix(), rand_pix(), rand_pix());
        read_pixel(6'd0, 6'd0);
        read_pixel(6'd4, 6'd0);
        read_pixel(6'd4, 6'd2);
        read_pixel(6'd63, 6'd63);
        read_pixel(6'd2, 6'd1);
        load_pixel(8'd200, 8'd100, 8'd50);
        read_pixel(6'd1, 6'd0);

        configure(64, 1, 64);
        repeat (64) load_pixel(8'd255, 8'd255, 8'd255);
        read_pixel(6'd63, 6'd0);
        read_pixel(6'd0, 6'd63);

        configure(0, 127, 0);
        repeat (70) random_item(40);

        configure(1, 64, 1);
        repeat (80) random_item(40);

        configure(7, 5, 100);
        repeat (60) random_item(40);

        while (items_sent < 1400) begin
            sel = $urandom_range(9);
            if (sel == 0) configure($urandom_range(1, 64), $urandom_range(1, 3),
                                    $urandom_range(1, 64));
            else if (sel == 1) configure($urandom, $urandom, $urandom);
            else if (sel < 5) begin
                model.write_reg(REG_TILE_SIZE, model.tile_reg);
                configure($urandom_range(1, 12), $urandom_range(1, 12), model.tile_reg);
            end else configure($urandom_range(1, 12), $urandom_range(1, 12),
                               $urandom_range(1, 6));
            n = $urandom_range(40, 120);
            quiet = ($urandom_range(7) == 0);
            if ($urandom_range(5) == 0) begin
                repeat (n / 2) random_item(10);
                hold_req = 1'b1;
                repeat (n / 2) random_item(90);
            end else begin
                repeat (n) random_item(35);
            end
            quiet = 1'b0;
        end

        quiet = 1'b1;
        repeat (60) random_item(40);
        hold_req = 1'b1;
        repeat (40) random_item(95);
        quiet = 1'b0;

        drain();
        if (model.errors == 0) begin
            $display("tile_average_mosaic_top test passed");
        end else begin
            $display("tile_average_mosaic_top test failed");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/tam_pkg.sv
rtl/tam_ctrl.sv
rtl/tam_datapath.sv
rtl/tile_average_mosaic_top.sv
tb/tb.sv
